// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the scatter-add block, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/ssamp_pkg.sv =====
// Package: sizes, codes and controller/datapath link types of the scatter-add block.
package ssamp_pkg;

	// Table geometry
	localparam int MAX_ROWS   = 1024;
	localparam int MAX_LANES  = 11;
	localparam int TBL_DEPTH  = MAX_ROWS * MAX_LANES;
	localparam int IDX_W      = $clog2(TBL_DEPTH);
	localparam int ROW_ADDR_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	// Field widths
	localparam int OP_W       = 2;
	localparam int ROW_IN_W   = 21;
	localparam int LANE_W     = 4;
	localparam int TAG_W      = 16;
	localparam int VALUE_W    = 32;
	localparam int DATA_W     = 31;
	localparam int STATUS_W   = 3;
	localparam int MASK_W     = 9;
	localparam int ROWCNT_W   = 11;
	localparam int TAG_LIMIT  = 512;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	localparam logic [DATA_W-1:0]   MODULUS_RST   = 31'h7FFF_FFFF;
	localparam logic [MASK_W-1:0]   CHAR_MASK_RST = '0;
	localparam logic [LANE_W-1:0]   LANES_RST     = 4'd1;
	localparam logic [ROWCNT_W-1:0] ROWS_RST      = 11'd1024;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_ACCUM = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 3'd0,
		STS_SKIP      = 3'd1,
		STS_BAD_ADDR  = 3'd2,
		STS_BAD_VALUE = 3'd3,
		STS_REFUSED   = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODULUS   = 2'd0,
		REG_CHAR_MASK = 2'd1,
		REG_LANES     = 2'd2,
		REG_ROWS      = 2'd3
	} cfg_reg_t;

	// Controller to datapath
	typedef struct packed {
		logic ld_in;
		logic check;
		logic mem_rd;
		logic add;
		logic mem_wr;
		logic sweep;
		logic ld_out;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_clear;
		logic is_accum;
		logic need_mem;
		logic sweep_last;
	} dp_status_t;

endpackage

// ===== hdl/ssamp_in_if.sv =====
// Input channel: one operation per transaction.
interface ssamp_in_if;
	logic                                valid;
	logic                                ready;
	logic [ssamp_pkg::OP_W-1:0]          operation;
	logic signed [ssamp_pkg::ROW_IN_W-1:0] row;
	logic [ssamp_pkg::LANE_W-1:0]        lane;
	logic [ssamp_pkg::TAG_W-1:0]         tag;
	logic [ssamp_pkg::VALUE_W-1:0]       value;

	modport source (output valid, output operation, output row, output lane, output tag,
		output value, input ready);
	modport sink (input valid, input operation, input row, input lane, input tag,
		input value, output ready);
endinterface

// ===== hdl/ssamp_out_if.sv =====
// Result channel: one result per transaction.
interface ssamp_out_if;
	logic                            valid;
	logic                            ready;
	logic [ssamp_pkg::DATA_W-1:0]    read_value;
	logic [ssamp_pkg::STATUS_W-1:0]  status;

	modport source (output valid, output read_value, output status, input ready);
	modport sink (input valid, input read_value, input status, output ready);
endinterface

// ===== hdl/ssamp_ctrl.sv =====
// Controller: sequences sweep, check, read-modify-write and result hand-off.
module ssamp_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_ready,
	output logic                    result_valid,
	input  logic                    result_ready,
	input  ssamp_pkg::dp_status_t   stat,
	output ssamp_pkg::dp_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_SWEEP_RST,
		S_SWEEP_OP,
		S_IDLE,
		S_CHECK,
		S_READ,
		S_ADD,
		S_WRITE,
		S_DONE
	} state_t;

	state_t state_q;
	logic   result_valid_q;
	logic   out_free;

	// Commands decoded from state
	always_comb begin
		out_free   = !result_valid_q || result_ready;
		item_ready = (state_q == S_IDLE);
		cmd        = '0;
		cmd.ld_in  = item_ready && item_valid;
		cmd.check  = (state_q == S_CHECK);
		cmd.mem_rd = (state_q == S_READ);
		cmd.add    = (state_q == S_ADD);
		cmd.mem_wr = (state_q == S_WRITE);
		cmd.sweep  = (state_q == S_SWEEP_RST) || (state_q == S_SWEEP_OP);
		cmd.ld_out = (state_q == S_DONE) && out_free;
	end

	assign result_valid = result_valid_q;

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_SWEEP_RST;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.ld_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_SWEEP_RST: begin
					if (stat.sweep_last) state_q <= S_IDLE;
				end
				S_SWEEP_OP: begin
					if (stat.sweep_last) state_q <= S_DONE;
				end
				S_IDLE: begin
					if (item_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					priority if (stat.is_clear) state_q <= S_SWEEP_OP;
					else if (stat.need_mem)     state_q <= S_READ;
					else                        state_q <= S_DONE;
				end
				S_READ: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					state_q <= stat.is_accum ? S_WRITE : S_DONE;
				end
				S_WRITE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/ssamp_dp.sv =====
// Datapath: configuration registers, entry table, checks and modular add.
module ssamp_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ssamp_pkg::dp_cmd_t                   cmd,
	output ssamp_pkg::dp_status_t                stat,
	input  logic [ssamp_pkg::OP_W-1:0]           operation,
	input  logic [ssamp_pkg::ROW_IN_W-1:0]       row,
	input  logic [ssamp_pkg::LANE_W-1:0]         lane,
	input  logic [ssamp_pkg::TAG_W-1:0]          tag,
	input  logic [ssamp_pkg::VALUE_W-1:0]        value,
	input  logic                                 cfg_we,
	input  logic [ssamp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssamp_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic [ssamp_pkg::DATA_W-1:0]         read_value,
	output logic [ssamp_pkg::STATUS_W-1:0]       status
);

	localparam int IDX_W    = ssamp_pkg::IDX_W;
	localparam int DATA_W   = ssamp_pkg::DATA_W;
	localparam int ROW_IN_W = ssamp_pkg::ROW_IN_W;
	localparam int LANE_W   = ssamp_pkg::LANE_W;

	// Configuration
	logic [DATA_W-1:0]               modulus_q;
	logic [ssamp_pkg::MASK_W-1:0]    char_mask_q;
	logic [LANE_W-1:0]               lanes_q;
	logic [ssamp_pkg::ROWCNT_W-1:0]  row_count_q;

	// Control state
	logic             error_q;
	logic [IDX_W-1:0] sweep_idx_q;

	// Captured item
	logic [ssamp_pkg::OP_W-1:0]    op_q;
	logic [ROW_IN_W-1:0]           row_q;
	logic [LANE_W-1:0]             lane_q;
	logic [ssamp_pkg::TAG_W-1:0]   tag_q;
	logic [ssamp_pkg::VALUE_W-1:0] value_q;

	// Work registers
	logic [IDX_W-1:0]               idx_q;
	logic [DATA_W-1:0]              addend_q;
	logic [DATA_W-1:0]              rd_q;
	logic [DATA_W:0]                sum_q;
	logic [DATA_W-1:0]              res_value_q;
	ssamp_pkg::status_t             res_status_q;
	logic [DATA_W-1:0]              read_value_q;
	logic [ssamp_pkg::STATUS_W-1:0] status_q;

	logic [DATA_W-1:0] mem [ssamp_pkg::TBL_DEPTH];

	// Check logic
	logic [ROW_IN_W-1:0]             rows_eff;
	logic [LANE_W-1:0]               lanes_eff;
	logic [ssamp_pkg::ROW_ADDR_W-1:0] row_lo;
	logic                            addr_ok;
	logic                            tag_bad;
	logic                            val_bad;
	logic                            negate;
	logic [IDX_W-1:0]                idx_calc;
	logic [DATA_W-1:0]               addend_calc;
	logic [DATA_W:0]                 mod_ext;
	logic [DATA_W-1:0]               wdata;
	ssamp_pkg::status_t              acc_st;
	ssamp_pkg::status_t              chk_st;
	logic                            is_accum;
	logic                            is_read;
	logic                            sweep_last;

	always_comb begin
		rows_eff  = (ROW_IN_W'(row_count_q) < ROW_IN_W'(ssamp_pkg::MAX_ROWS)) ?
			ROW_IN_W'(row_count_q) : ROW_IN_W'(ssamp_pkg::MAX_ROWS);
		lanes_eff = (lanes_q < LANE_W'(ssamp_pkg::MAX_LANES)) ?
			lanes_q : LANE_W'(ssamp_pkg::MAX_LANES);
		row_lo    = row_q[ssamp_pkg::ROW_ADDR_W-1:0];
		addr_ok   = !row_q[ROW_IN_W-1] &&
			({1'b0, row_q[ROW_IN_W-2:0]} < rows_eff) && (lane_q < lanes_eff);
		idx_calc  = IDX_W'(row_lo) * IDX_W'(ssamp_pkg::MAX_LANES) + IDX_W'(lane_q);
		tag_bad   = (tag_q >= ssamp_pkg::TAG_W'(ssamp_pkg::TAG_LIMIT));
		mod_ext   = {1'b0, modulus_q};
		val_bad   = (value_q >= mod_ext);
		negate    = (^(tag_q[ssamp_pkg::MASK_W-1:0] & char_mask_q)) && (value_q != '0);
		addend_calc = negate ? (modulus_q - value_q[DATA_W-1:0]) : value_q[DATA_W-1:0];
		is_accum  = (op_q == ssamp_pkg::OP_ACCUM);
		is_read   = (op_q == ssamp_pkg::OP_READ);

		// Accumulate checks in priority order
		priority if (error_q)               acc_st = ssamp_pkg::STS_REFUSED;
		else if (row_q[ROW_IN_W-1])         acc_st = ssamp_pkg::STS_SKIP;
		else if (!addr_ok || tag_bad)       acc_st = ssamp_pkg::STS_BAD_ADDR;
		else if (val_bad)                   acc_st = ssamp_pkg::STS_BAD_VALUE;
		else                                acc_st = ssamp_pkg::STS_OK;

		if (is_accum)     chk_st = acc_st;
		else if (is_read) chk_st = addr_ok ? ssamp_pkg::STS_OK : ssamp_pkg::STS_BAD_ADDR;
		else              chk_st = ssamp_pkg::STS_OK;

		// Single conditional subtract keeps the sum below p when the stored entry is below p
		wdata = (sum_q >= mod_ext) ? DATA_W'(sum_q - mod_ext) : sum_q[DATA_W-1:0];

		sweep_last = (sweep_idx_q == IDX_W'(ssamp_pkg::TBL_DEPTH - 1));
	end

	assign stat.is_clear   = (op_q == ssamp_pkg::OP_CLEAR);
	assign stat.is_accum   = is_accum;
	assign stat.need_mem   = (is_accum && (acc_st == ssamp_pkg::STS_OK)) || (is_read && addr_ok);
	assign stat.sweep_last = sweep_last;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= ssamp_pkg::MODULUS_RST;
			char_mask_q <= ssamp_pkg::CHAR_MASK_RST;
			lanes_q     <= ssamp_pkg::LANES_RST;
			row_count_q <= ssamp_pkg::ROWS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssamp_pkg::REG_MODULUS:   modulus_q   <= cfg_data[DATA_W-1:0];
				ssamp_pkg::REG_CHAR_MASK: char_mask_q <= cfg_data[ssamp_pkg::MASK_W-1:0];
				ssamp_pkg::REG_LANES:     lanes_q     <= cfg_data[LANE_W-1:0];
				ssamp_pkg::REG_ROWS:      row_count_q <= cfg_data[ssamp_pkg::ROWCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sticky error and sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_q     <= 1'b0;
			sweep_idx_q <= '0;
		end else begin
			if (cmd.check && stat.is_clear) begin
				error_q <= 1'b0;
			end else if (cmd.check && is_accum &&
				(acc_st == ssamp_pkg::STS_BAD_ADDR || acc_st == ssamp_pkg::STS_BAD_VALUE)) begin
				error_q <= 1'b1;
			end
			if (cmd.sweep) begin
				sweep_idx_q <= sweep_last ? '0 : sweep_idx_q + 1'b1;
			end
		end
	end

	// Item capture and work registers
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			op_q    <= operation;
			row_q   <= row;
			lane_q  <= lane;
			tag_q   <= tag;
			value_q <= value;
		end
		if (cmd.check) begin
			idx_q        <= idx_calc;
			addend_q     <= addend_calc;
			res_value_q  <= '0;
			res_status_q <= chk_st;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[idx_q];
		end
		if (cmd.add) begin
			sum_q <= {1'b0, rd_q} + {1'b0, addend_q};
			if (is_read) res_value_q <= rd_q;
		end
		if (cmd.ld_out) begin
			read_value_q <= res_value_q;
			status_q     <= res_status_q;
		end
	end

	// Table write port: sweep or accumulate write-back
	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			mem[sweep_idx_q] <= '0;
		end else if (cmd.mem_wr) begin
			mem[idx_q] <= wdata;
		end
	end

	assign read_value = read_value_q;
	assign status     = status_q;

endmodule

// ===== hdl/signed_scatter_add_mod_p_top.sv =====
// Top level of the signed scatter-add modulo p block.
// Table of 1024 rows x 11 lanes of 31-bit residues in one single-port memory, handled one
// transaction at a time. After reset the block sweeps the table to zero before it takes its
// first transaction. Accumulate runs through check, memory read, add, reduce and write
// back, and result hand-off; read runs through check, memory read, result capture and
// hand-off; skipped, failed or unused operations run through check and hand-off; clear
// sweeps the table, one table entry zeroed per cycle, and then hands off. The result sits in
// an output register, so the next transaction is taken while a result waits; configuration
// writes are taken at any time, also during a sweep.
`include "assert_macros.svh"

module signed_scatter_add_mod_p_top (
	input  logic                                clk,
	input  logic                                arst_n,
	ssamp_in_if.sink                            item,
	ssamp_out_if.source                         result,
	input  logic                                cfg_we,
	input  logic [ssamp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ssamp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	ssamp_pkg::dp_cmd_t    cmd;
	ssamp_pkg::dp_status_t stat;
	logic                  item_ready;
	logic                  result_valid;

	ssamp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	ssamp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.operation  (item.operation),
		.row        (item.row),
		.lane       (item.lane),
		.tag        (item.tag),
		.value      (item.value),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.read_value (result.read_value),
		.status     (result.status)
	);

	assign item.ready   = item_ready;
	assign result.valid = result_valid;

	// Checks on sequencing
	`ASSERT_ALWAYS(a_one_in_flight, item.valid && item.ready |=> !item.ready, "second transaction taken while busy")
	`ASSERT_ALWAYS(a_check_follows_accept, cmd.ld_in |=> cmd.check, "check step missed after accept")
	`ASSERT_ALWAYS(a_no_result_overwrite, cmd.ld_out |-> (!result.valid || result.ready), "pending result overwritten")
	`ASSERT_NEVER(a_no_write_while_ready, (cmd.mem_wr || cmd.sweep) && item.ready, "table written while accepting")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the signed scatter-add modulo p block, with its own table model.
module testbench;

	localparam logic [ssamp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_PHASES = 10;
	localparam int OPS_PER_PHASE = 113;
	localparam int QUIET_LIMIT   = 50000;
	localparam int DRAIN_CYCLES  = 16;
	localparam int LONG_HOLD     = 400;

	typedef struct {
		logic [ssamp_pkg::OP_W-1:0]            operation;
		logic signed [ssamp_pkg::ROW_IN_W-1:0] row;
		logic [ssamp_pkg::LANE_W-1:0]          lane;
		logic [ssamp_pkg::TAG_W-1:0]           tag;
		logic [ssamp_pkg::VALUE_W-1:0]         value;
	} scatter_op_t;

	typedef struct {
		logic [ssamp_pkg::DATA_W-1:0] read_value;
		ssamp_pkg::status_t           status;
	} scatter_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [ssamp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ssamp_pkg::CFG_DATA_W-1:0] cfg_data;

	ssamp_in_if item_if();
	ssamp_out_if result_if();

	signed_scatter_add_mod_p_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_if),
		.result(result_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Model state: table, sticky error and register copies
	logic [ssamp_pkg::DATA_W-1:0]   sum_table [ssamp_pkg::TBL_DEPTH];
	logic                           err_sticky = 1'b0;
	logic [ssamp_pkg::DATA_W-1:0]   cfg_modulus = ssamp_pkg::MODULUS_RST;
	logic [ssamp_pkg::MASK_W-1:0]   cfg_char_mask = ssamp_pkg::CHAR_MASK_RST;
	logic [ssamp_pkg::LANE_W-1:0]   cfg_lanes = ssamp_pkg::LANES_RST;
	logic [ssamp_pkg::ROWCNT_W-1:0] cfg_rows = ssamp_pkg::ROWS_RST;

	scatter_op_t     pending_ops [$];
	scatter_result_t expected_results [$];
	scatter_op_t     in_flight;
	bit op_taken = 1'b0;
	bit steady = 1'b0;
	int gap_left = 0;
	int hold_left = 0;
	int n_queued = 0;
	int n_accepted = 0;
	int n_results = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	function automatic int rows_in_use();
		return (int'(cfg_rows) < ssamp_pkg::MAX_ROWS) ? int'(cfg_rows) : ssamp_pkg::MAX_ROWS;
	endfunction

	function automatic int lanes_in_use();
		return (int'(cfg_lanes) < ssamp_pkg::MAX_LANES) ? int'(cfg_lanes) : ssamp_pkg::MAX_LANES;
	endfunction

	// Row/lane to table slot; fails for a negative row or one outside the rows and lanes in use
	function automatic bit entry_index(input scatter_op_t op, output int idx);
		int r;
		idx = 0;
		r = int'(op.row[ssamp_pkg::ROW_IN_W-2:0]);
		if (op.row[ssamp_pkg::ROW_IN_W-1])
			return 1'b0;
		if (r >= rows_in_use() || int'(op.lane) >= lanes_in_use())
			return 1'b0;
		idx = r * ssamp_pkg::MAX_LANES + int'(op.lane);
		return 1'b1;
	endfunction

	// Applies one operation to the model and returns the result it must produce
	function automatic scatter_result_t apply_scatter(input scatter_op_t op);
		scatter_result_t res;
		int idx;
		bit hit;
		longint unsigned p, v, s;
		res.read_value = '0;
		res.status = ssamp_pkg::STS_OK;
		hit = entry_index(op, idx);
		p = 64'(cfg_modulus);
		v = 64'(op.value);
		case (op.operation)
			ssamp_pkg::OP_CLEAR: begin
				foreach (sum_table[i])
					sum_table[i] = '0;
				err_sticky = 1'b0;
			end
			ssamp_pkg::OP_ACCUM: begin
				if (err_sticky)
					res.status = ssamp_pkg::STS_REFUSED;
				else if (op.row[ssamp_pkg::ROW_IN_W-1])
					res.status = ssamp_pkg::STS_SKIP;
				else if (!hit || op.tag >= ssamp_pkg::TAG_W'(ssamp_pkg::TAG_LIMIT)) begin
					res.status = ssamp_pkg::STS_BAD_ADDR;
					err_sticky = 1'b1;
				end else if (v >= p) begin
					res.status = ssamp_pkg::STS_BAD_VALUE;
					err_sticky = 1'b1;
				end else begin
					// odd parity of the masked tag negates; zero stays zero
					if (^(op.tag[ssamp_pkg::MASK_W-1:0] & cfg_char_mask) && v != 0)
						v = p - v;
					// entry may be stale from a larger modulus: one subtraction only
					s = 64'(sum_table[idx]) + v;
					if (s >= p)
						s = s - p;
					sum_table[idx] = s[ssamp_pkg::DATA_W-1:0];
				end
			end
			ssamp_pkg::OP_READ: begin
				if (hit)
					res.read_value = sum_table[idx];
				else
					res.status = ssamp_pkg::STS_BAD_ADDR;
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic scatter_op_t make_op(input logic [ssamp_pkg::OP_W-1:0] operation,
		input int row, input int lane, input int tag,
		input logic [ssamp_pkg::VALUE_W-1:0] value);
		scatter_op_t op;
		op.operation = operation;
		op.row = ssamp_pkg::ROW_IN_W'(row);
		op.lane = ssamp_pkg::LANE_W'(lane);
		op.tag = ssamp_pkg::TAG_W'(tag);
		op.value = value;
		return op;
	endfunction

	// Mostly well-formed accumulates and reads on a few hot rows, some skips and rare errors
	function automatic scatter_op_t random_op();
		scatter_op_t op;
		int unsigned r, rows, lanes, hot;
		rows = rows_in_use();
		lanes = lanes_in_use();
		hot = (rows < 4) ? rows : 4;
		op.operation = ssamp_pkg::OP_ACCUM;
		if ($urandom_range(0, 9) < 7)
			op.row = ssamp_pkg::ROW_IN_W'($urandom_range(0, hot - 1));
		else
			op.row = ssamp_pkg::ROW_IN_W'($urandom_range(0, rows - 1));
		op.lane = ssamp_pkg::LANE_W'($urandom_range(0, lanes - 1));
		op.tag = ssamp_pkg::TAG_W'($urandom_range(0, ssamp_pkg::TAG_LIMIT - 1));
		case ($urandom_range(0, 9))
			0: op.value = '0;
			1: op.value = 32'(cfg_modulus) - 1;
			default: op.value = $urandom_range(0, 32'(cfg_modulus) - 1);
		endcase
		r = $urandom_range(0, 999);
		if (r < 8) begin
			op.operation = ssamp_pkg::OP_CLEAR;
		end else if (r < 20) begin
			case ($urandom_range(0, 3))
				0: op.row = ssamp_pkg::ROW_IN_W'($urandom_range(rows, 1048575));
				1: begin
					if (lanes < ssamp_pkg::MAX_LANES)
						op.lane = ssamp_pkg::LANE_W'($urandom_range(lanes,
							ssamp_pkg::MAX_LANES - 1));
					else
						op.row = ssamp_pkg::ROW_IN_W'($urandom_range(rows, 1048575));
				end
				2: op.tag = ssamp_pkg::TAG_W'($urandom_range(ssamp_pkg::TAG_LIMIT, 65535));
				default: op.value = $urandom_range(32'(cfg_modulus), 32'hFFFF_FFFF);
			endcase
		end else if (r < 60) begin
			op.row = '1;
		end else if (r < 320) begin
			op.operation = ssamp_pkg::OP_READ;
			if ($urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 1) != 0)
					op.row = '1;
				else
					op.row = ssamp_pkg::ROW_IN_W'($urandom_range(rows, 1048575));
			end
		end
		return op;
	endfunction

	task automatic queue_op(input scatter_op_t op);
		pending_ops.push_back(op);
		n_queued++;
	endtask

	task automatic write_reg(input ssamp_pkg::cfg_reg_t idx,
		input logic [ssamp_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ssamp_pkg::REG_MODULUS:   cfg_modulus = data[ssamp_pkg::DATA_W-1:0];
			ssamp_pkg::REG_CHAR_MASK: cfg_char_mask = data[ssamp_pkg::MASK_W-1:0];
			ssamp_pkg::REG_LANES:     cfg_lanes = data[ssamp_pkg::LANE_W-1:0];
			default:                  cfg_rows = data[ssamp_pkg::ROWCNT_W-1:0];
		endcase
	endtask

	task automatic apply_setting(input logic [ssamp_pkg::DATA_W-1:0] modulus,
		input logic [ssamp_pkg::MASK_W-1:0] mask, input logic [ssamp_pkg::LANE_W-1:0] lanes,
		input logic [ssamp_pkg::ROWCNT_W-1:0] rows);
		write_reg(ssamp_pkg::REG_MODULUS, modulus);
		write_reg(ssamp_pkg::REG_CHAR_MASK, ssamp_pkg::CFG_DATA_W'(mask));
		write_reg(ssamp_pkg::REG_LANES, ssamp_pkg::CFG_DATA_W'(lanes));
		write_reg(ssamp_pkg::REG_ROWS, ssamp_pkg::CFG_DATA_W'(rows));
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("result %0d: %s is %0d, expected %0d", n_results, what, got, want);
	endtask

	// Driver: offers the next operation once the previous one is accepted, after an optional gap
	always @(negedge clk) begin
		if (arst_n && (!item_if.valid || op_taken)) begin
			op_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				item_if.valid <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				in_flight = pending_ops.pop_front();
				item_if.operation <= in_flight.operation;
				item_if.row <= in_flight.row;
				item_if.lane <= in_flight.lane;
				item_if.tag <= in_flight.tag;
				item_if.value <= in_flight.value;
				item_if.valid <= 1'b1;
				gap_left = steady ? 0 : $urandom_range(0, 4);
			end else begin
				item_if.valid <= 1'b0;
			end
		end
	end

	// Accepted operation: update the model and queue its result
	always @(posedge clk) begin
		if (arst_n && item_if.valid && item_if.ready) begin
			expected_results.push_back(apply_scatter(in_flight));
			n_accepted++;
			op_taken = 1'b1;
		end
	end

	// Monitor: compare each result with the oldest expected one, then draw the next stall
	always @(posedge clk) begin
		scatter_result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			n_results++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing pending, status",
					longint'(result_if.status), 0);
			end else begin
				want = expected_results.pop_front();
				if (result_if.read_value !== want.read_value)
					report_mismatch("read_value", longint'(result_if.read_value),
						longint'(want.read_value));
				if (result_if.status !== want.status)
					report_mismatch("status", longint'(result_if.status),
						longint'(want.status));
			end
			// two long holds let the block fill up and push back on its input
			if (n_results == 300 || n_results == 800)
				hold_left = LONG_HOLD;
			else
				hold_left = steady ? 0 : $urandom_range(0, 4);
		end
	end

	// Receiver ready
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog: a clear sweep is the longest correct stretch without any transaction
	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [ssamp_pkg::DATA_W-1:0] rand_mod;
		logic [ssamp_pkg::ROWCNT_W-1:0] rand_rows;
		foreach (sum_table[i])
			sum_table[i] = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = ssamp_pkg::REG_MODULUS;
		cfg_data = '0;
		item_if.valid = 1'b0;
		item_if.operation = ssamp_pkg::OP_CLEAR;
		item_if.row = '0;
		item_if.lane = '0;
		item_if.tag = '0;
		item_if.value = '0;
		result_if.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: largest modulus, full mask, full geometry
		apply_setting(31'h7FFF_FFFF, 9'h1FF, 4'd11, 11'd1024);
		@(posedge clk);
		queue_op(make_op(ssamp_pkg::OP_ACCUM, 0, 0, 0, 32'h7FFF_FFFE)); // largest value
		queue_op(make_op(ssamp_pkg::OP_ACCUM, 0, 0, 1, 32'd5)); // odd parity: negated, wraps
		queue_op(make_op(ssamp_pkg::OP_ACCUM, 0, 0, 3, 32'd7)); // even parity, sum wraps
		queue_op(make_op(ssamp_pkg::OP_ACCUM, 1023, 10, 511, 32'd0)); // negated zero stays zero
		queue_op(make_op(ssamp_pkg::OP_ACCUM, 1023, 10, 256, 32'd123)); // last row and lane
		queue_op(make_op(ssamp_pkg::OP_READ, 0, 0, 0, 32'd0));
		queue_op(make_op(ssamp_pkg::OP_READ, 1023, 10, 65535, 32'hFFFF_FFFF));
		queue_op(make_op(ssamp_pkg::OP_READ, -1, 0, 0, 32'd0)); // negative read address
		queue_op(make_op(ssamp_pkg::OP_READ, 1024, 0, 0, 32'd0)); // row past the end
		queue_op(make_op(ssamp_pkg::OP_READ, 5, 10, 0, 32'd0));
		queue_op(make_op(OP_UNUSED, 1048575, 10, 65535, 32'hFFFF_FFFF));
		queue_op(make_op(ssamp_pkg::OP_ACCUM, -1, 10, 65535, 32'hFFFF_FFFF)); // skipped element
		queue_op(make_op(ssamp_pkg::OP_ACCUM, 0, 0, 0, 32'h7FFF_FFFF)); // value equal to modulus
		queue_op(make_op(ssamp_pkg::OP_ACCUM, 0, 0, 0, 32'd1)); // refused after the error
		queue_op(make_op(ssamp_pkg::OP_ACCUM, -1, 0, 0, 32'd1)); // a skip is refused too
		queue_op(make_op(ssamp_pkg::OP_READ, 0, 0, 0, 32'd0)); // reads ignore the error
		queue_op(make_op(ssamp_pkg::OP_CLEAR, 0, 0, 0, 32'd0));
		queue_op(make_op(ssamp_pkg::OP_ACCUM, 1048575, 0, 0, 32'd1)); // largest row
		queue_op(make_op(ssamp_pkg::OP_CLEAR, 0, 0, 0, 32'd0));
		queue_op(make_op(ssamp_pkg::OP_ACCUM, 0, 0, 65535, 32'd0)); // tag out of range
		queue_op(make_op(ssamp_pkg::OP_CLEAR, 0, 0, 0, 32'd0));
		queue_op(make_op(ssamp_pkg::OP_ACCUM, 0, 0, 0, 32'hFFFF_FFFF)); // largest value field
		queue_op(make_op(ssamp_pkg::OP_CLEAR, 0, 0, 0, 32'd0));
		queue_op(make_op(ssamp_pkg::OP_READ, 0, 0, 0, 32'd0));

		// Random phases, one register setting each
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: apply_setting(31'h7FFF_FFFF, 9'h0F0, 4'd11, 11'd1024);
				1: apply_setting(31'd2, 9'h001, 4'd1, 11'd1);   // stale entries, no clear
				2: apply_setting(31'd3, 9'h100, 4'd2, 11'd2);
				RANDOM_PHASES - 1: apply_setting(ssamp_pkg::MODULUS_RST,
					ssamp_pkg::CHAR_MASK_RST, ssamp_pkg::LANES_RST, ssamp_pkg::ROWS_RST);
				default: begin
					if ($urandom_range(0, 1) != 0)
						rand_mod = ssamp_pkg::DATA_W'($urandom_range(2, 32'h7FFF_FFFF));
					else
						rand_mod = ssamp_pkg::DATA_W'($urandom_range(2, 40));
					if ($urandom_range(0, 1) != 0)
						rand_rows = ssamp_pkg::ROWCNT_W'($urandom_range(1, 1024));
					else
						rand_rows = ssamp_pkg::ROWCNT_W'($urandom_range(1, 8));
					apply_setting(rand_mod, ssamp_pkg::MASK_W'($urandom_range(0, 511)),
						ssamp_pkg::LANE_W'($urandom_range(1, 11)), rand_rows);
				end
			endcase
			steady = (ph == 0) || ($urandom_range(0, 3) == 0);
			@(posedge clk);
			if (ph == 2 || (ph > 2 && $urandom_range(0, 3) != 0))
				queue_op(make_op(ssamp_pkg::OP_CLEAR, 0, 0, 0, 32'd0));
			repeat (OPS_PER_PHASE) queue_op(random_op());
		end

		wait_drained();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
